### sv/hcsm_pkg.sv
// Shared types and constants of the hall commutation speed meter.
package hcsm_pkg;

	// Field and register widths fixed by the interface.
	localparam int HALL_W    = 3;
	localparam int STEP_W    = 3;
	localparam int SECTOR_W  = 3;
	localparam int TIMEOUT_W = 16;
	localparam int NUM_W     = 32;
	localparam int MAP_W     = 18;
	localparam int TABLE_W   = 36;
	localparam int ROW_W     = 18;
	localparam int OUT_SPD_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 36;
	localparam int S_DATA_W  = 8;
	localparam int M_DATA_W  = 40;

	// Six periods make one electrical revolution.
	localparam int RING_DEPTH = 6;
	localparam int PTR_W      = 3;

	// Register reset values.
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd5000;
	localparam logic [NUM_W-1:0]     NUMER_RESET   = 32'd1200000;
	localparam logic [MAP_W-1:0]     MAP_RESET     = 18'd152278;
	localparam logic [TABLE_W-1:0]   TABLE_RESET   = 36'd28163847285;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUMER   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAP     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TABLE   = 2'd3;

	// Sequencer states.
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_EVAL = 6'b000010,
		ST_COMM = 6'b000100,
		ST_LOAD = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	// Divider status seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

	// Period ring commands from the sequencer.
	typedef struct packed {
		logic fill;
		logic write;
	} ring_ctl_t;

endpackage

### sv/hall_commutation_speed_meter.sv
// Top level of the hall commutation speed meter.
//
// One transaction on the s_ side is one control tick: the three hall lines
// and the direction bit. Each tick yields exactly one result on the m_ side.
// A tick without commutation passes the evaluate and output states; one with
// commutation also passes the commutate, load and divide states, where the
// bit-serial divider gives one quotient bit per cycle for the 32-bit speed
// numerator. A new tick is accepted once the previous one has reached the
// result register, which may still wait for m_tready. Configuration writes
// are taken at any time but are meant for when the block is idle.
module hall_commutation_speed_meter #(
	parameter int COUNT_WIDTH = 16,
	parameter int SPEED_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Tick input: [2:0] hall_bits, [3] reverse, [7:4] zero.
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [hcsm_pkg::S_DATA_W-1:0]    s_tdata,
	// Result: [0] commutate, [3:1] drive_step, [35:4] speed, [36] stopped,
	// [37] hall_invalid, [39:38] zero.
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [hcsm_pkg::M_DATA_W-1:0]    m_tdata,
	// Register write channel.
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [hcsm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hcsm_pkg::CFG_DAT_W-1:0]   cfg_data
);

	localparam int SUM_W = COUNT_WIDTH + 3;
	localparam int CMP_W = (COUNT_WIDTH > hcsm_pkg::TIMEOUT_W) ?
		COUNT_WIDTH : hcsm_pkg::TIMEOUT_W;
	localparam int MAG_W = (SPEED_WIDTH > hcsm_pkg::NUM_W + 1) ?
		SPEED_WIDTH : hcsm_pkg::NUM_W + 1;
	localparam int EXT_W = (SPEED_WIDTH > hcsm_pkg::OUT_SPD_W) ?
		SPEED_WIDTH : hcsm_pkg::OUT_SPD_W;

	// Configuration registers.
	logic [hcsm_pkg::TIMEOUT_W-1:0] timeout_q;
	logic [hcsm_pkg::NUM_W-1:0]     numer_q;
	logic [hcsm_pkg::MAP_W-1:0]     map_q;
	logic [hcsm_pkg::TABLE_W-1:0]   table_q;

	// Sequencer and motor state.
	hcsm_pkg::state_t                state_q;
	logic [COUNT_WIDTH-1:0]          tick_q;
	logic [hcsm_pkg::SECTOR_W-1:0]   last_q;
	logic [hcsm_pkg::STEP_W-1:0]     step_q;
	logic signed [SPEED_WIDTH-1:0]   speed_q;

	// Captured tick and per-tick flags.
	logic [hcsm_pkg::HALL_W-1:0]     hall_q;
	logic                            rev_q;
	logic [COUNT_WIDTH-1:0]          period_q;
	logic                            comm_q;
	logic                            stop_q;
	logic                            inval_q;

	// Result register.
	logic                            m_tvalid_q;
	logic [hcsm_pkg::M_DATA_W-1:0]   m_tdata_q;

	logic [COUNT_WIDTH-1:0]          tick_inc;
	logic                            over;
	logic [COUNT_WIDTH-1:0]          tick_clamp;
	logic [COUNT_WIDTH-1:0]          timeout_cw;
	logic [hcsm_pkg::SECTOR_W-1:0]   sector;
	logic                            comm;
	logic [hcsm_pkg::ROW_W-1:0]      row;
	logic [hcsm_pkg::STEP_W-1:0]     step_new;
	hcsm_pkg::ring_ctl_t             ring_ctl;
	logic [SUM_W-1:0]                ring_sum;
	logic [SUM_W-1:0]                divisor;
	logic [hcsm_pkg::NUM_W-1:0]      quotient;
	hcsm_pkg::div_status_t           div_st;
	logic [MAG_W-1:0]                q_ext;
	logic [MAG_W-1:0]                mag_lim;
	logic [MAG_W-1:0]                mag;
	logic signed [SPEED_WIDTH-1:0]   speed_new;
	logic signed [EXT_W-1:0]         speed_ext;
	logic                            out_load;

	// Configuration write channel, always ready.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= hcsm_pkg::TIMEOUT_RESET;
			numer_q   <= hcsm_pkg::NUMER_RESET;
			map_q     <= hcsm_pkg::MAP_RESET;
			table_q   <= hcsm_pkg::TABLE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				hcsm_pkg::REG_TIMEOUT: timeout_q <= cfg_data[hcsm_pkg::TIMEOUT_W-1:0];
				hcsm_pkg::REG_NUMER:   numer_q   <= cfg_data[hcsm_pkg::NUM_W-1:0];
				hcsm_pkg::REG_MAP:     map_q     <= cfg_data[hcsm_pkg::MAP_W-1:0];
				hcsm_pkg::REG_TABLE:   table_q   <= cfg_data[hcsm_pkg::TABLE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Tick counter with saturation and timeout clamp.
	assign timeout_cw = COUNT_WIDTH'(timeout_q);
	assign tick_inc   = (tick_q == {COUNT_WIDTH{1'b1}}) ? tick_q : tick_q + 1'b1;
	assign over       = CMP_W'(tick_inc) > CMP_W'(timeout_q);
	assign tick_clamp = over ? timeout_cw : tick_inc;

	// Hall decode: the lowest map entry that matches wins.
	always_comb begin
		sector = '0;
		for (int i = hcsm_pkg::RING_DEPTH - 1; i >= 0; i--) begin
			if (map_q[hcsm_pkg::HALL_W*i +: hcsm_pkg::HALL_W] == hall_q) begin
				sector = hcsm_pkg::SECTOR_W'(i + 1);
			end
		end
	end

	assign comm = (sector != '0) && ((sector != last_q) || (step_q == '0));

	// Next drive step from the forward or reverse row.
	assign row = rev_q ? table_q[hcsm_pkg::TABLE_W-1:hcsm_pkg::ROW_W]
	                   : table_q[hcsm_pkg::ROW_W-1:0];

	always_comb begin
		case (sector)
			3'd1:    step_new = row[2:0];
			3'd2:    step_new = row[5:3];
			3'd3:    step_new = row[8:6];
			3'd4:    step_new = row[11:9];
			3'd5:    step_new = row[14:12];
			3'd6:    step_new = row[17:15];
			default: step_new = '0;
		endcase
	end

	// Period ring and its running sum.
	assign ring_ctl.fill  = (state_q == hcsm_pkg::ST_EVAL) && over;
	assign ring_ctl.write = (state_q == hcsm_pkg::ST_COMM);

	hcsm_period_ring #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_ring (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ring_ctl),
		.fill_value (timeout_cw),
		.write_value(period_q),
		.sum        (ring_sum)
	);

	// Speed division; an all-zero ring divides by one.
	assign divisor = (ring_sum == '0) ? SUM_W'(1) : ring_sum;

	hcsm_divider #(
		.DIVIDEND_W(hcsm_pkg::NUM_W),
		.DIVISOR_W (SUM_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == hcsm_pkg::ST_LOAD),
		.dividend(numer_q),
		.divisor (divisor),
		.quotient(quotient),
		.status  (div_st)
	);

	// Saturate the magnitude, then apply the direction.
	assign q_ext     = MAG_W'(quotient);
	assign mag_lim   = MAG_W'({1'b0, {(SPEED_WIDTH-1){1'b1}}});
	assign mag       = (q_ext > mag_lim) ? mag_lim : q_ext;
	assign speed_new = rev_q ? -$signed(SPEED_WIDTH'(mag)) : $signed(SPEED_WIDTH'(mag));
	assign speed_ext = EXT_W'(speed_q);

	assign out_load = (state_q == hcsm_pkg::ST_OUT) && (!m_tvalid_q || m_tready);

	// Sequencer and motor state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hcsm_pkg::ST_IDLE;
			tick_q  <= '0;
			last_q  <= '0;
			step_q  <= '0;
			speed_q <= '0;
		end else begin
			case (state_q)
				hcsm_pkg::ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= hcsm_pkg::ST_EVAL;
					end
				end
				hcsm_pkg::ST_EVAL: begin
					tick_q <= comm ? '0 : tick_clamp;
					if (over) begin
						speed_q <= '0;
					end
					if (sector != '0) begin
						last_q <= sector;
					end
					if (comm) begin
						step_q  <= step_new;
						state_q <= hcsm_pkg::ST_COMM;
					end else begin
						state_q <= hcsm_pkg::ST_OUT;
					end
				end
				hcsm_pkg::ST_COMM: state_q <= hcsm_pkg::ST_LOAD;
				hcsm_pkg::ST_LOAD: state_q <= hcsm_pkg::ST_DIV;
				hcsm_pkg::ST_DIV: begin
					if (div_st.done) begin
						speed_q <= speed_new;
						state_q <= hcsm_pkg::ST_OUT;
					end
				end
				hcsm_pkg::ST_OUT: begin
					if (out_load) begin
						state_q <= hcsm_pkg::ST_IDLE;
					end
				end
				default: state_q <= hcsm_pkg::ST_IDLE;
			endcase
		end
	end

	// Tick capture and per-tick flags.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			hall_q <= s_tdata[hcsm_pkg::HALL_W-1:0];
			rev_q  <= s_tdata[hcsm_pkg::HALL_W];
		end
		if (state_q == hcsm_pkg::ST_EVAL) begin
			period_q <= tick_clamp;
			comm_q   <= comm;
			stop_q   <= over;
			inval_q  <= (sector == '0);
		end
	end

	// Result register parts the sequencer from the output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {2'b00, inval_q, stop_q,
			              speed_ext[hcsm_pkg::OUT_SPD_W-1:0], step_q, comm_q};
		end
	end

	assign s_tready = (state_q == hcsm_pkg::ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTHESIS
	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.busy |-> (state_q == hcsm_pkg::ST_DIV))
		else $error("divider running outside the divide state");
	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == hcsm_pkg::ST_EVAL))
		else $error("accepted tick not evaluated");
	a_inval_nocomm: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hcsm_pkg::ST_OUT) |-> !(inval_q && comm_q))
		else $error("commutation on an invalid hall code");
`endif

endmodule

### sv/hcsm_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module hcsm_divider #(
	parameter int DIVIDEND_W = 32,
	parameter int DIVISOR_W  = 19
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic [DIVIDEND_W-1:0] quotient,
	output hcsm_pkg::div_status_t status
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] dvd_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dsr_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DIVISOR_W:0]    shifted;
	logic [DIVISOR_W:0]    trial;
	logic                  fits;

	// One restoring step: shift in the next dividend bit and try the subtract.
	assign shifted = {rem_q, dvd_q[DIVIDEND_W-1]};
	assign fits    = shifted >= {1'b0, dsr_q};
	assign trial   = shifted - {1'b0, dsr_q};

	// Control: count the steps and flag completion for one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the quotient bits shift into the emptied dividend register.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
		end
	end

	assign quotient    = dvd_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

### sv/hcsm_period_ring.sv
// Ring of six commutation periods with a running sum.
module hcsm_period_ring #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  hcsm_pkg::ring_ctl_t    ctl,
	input  logic [COUNT_WIDTH-1:0] fill_value,
	input  logic [COUNT_WIDTH-1:0] write_value,
	output logic [COUNT_WIDTH+2:0] sum
);

	localparam int SUM_W = COUNT_WIDTH + 3;
	localparam logic [COUNT_WIDTH-1:0] ENTRY_RST = COUNT_WIDTH'(hcsm_pkg::TIMEOUT_RESET);
	localparam logic [SUM_W-1:0] SUM_RST =
		SUM_W'(ENTRY_RST) * SUM_W'(hcsm_pkg::RING_DEPTH);
	localparam logic [hcsm_pkg::PTR_W-1:0] PTR_LAST =
		hcsm_pkg::PTR_W'(hcsm_pkg::RING_DEPTH - 1);

	logic [COUNT_WIDTH-1:0]     entry_q [hcsm_pkg::RING_DEPTH];
	logic [hcsm_pkg::PTR_W-1:0] ptr_q;
	logic [hcsm_pkg::PTR_W-1:0] ptr_nxt;
	logic [SUM_W-1:0]           sum_q;
	logic [SUM_W-1:0]           fill_x6;

	assign ptr_nxt = (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;
	assign fill_x6 = (SUM_W'(fill_value) << 2) + (SUM_W'(fill_value) << 1);

	// A fill sets every period to the timeout; a write replaces the oldest one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < hcsm_pkg::RING_DEPTH; i++) begin
				entry_q[i] <= ENTRY_RST;
			end
			ptr_q <= '0;
			sum_q <= SUM_RST;
		end else if (ctl.fill) begin
			for (int i = 0; i < hcsm_pkg::RING_DEPTH; i++) begin
				entry_q[i] <= fill_value;
			end
			sum_q <= fill_x6;
		end else if (ctl.write) begin
			entry_q[ptr_nxt] <= write_value;
			ptr_q            <= ptr_nxt;
			sum_q            <= sum_q - SUM_W'(entry_q[ptr_nxt]) + SUM_W'(write_value);
		end
	end

	assign sum = sum_q;

`ifndef SYNTHESIS
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= PTR_LAST)
		else $error("ring pointer left the ring");
	a_fill_sum: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fill |=> sum_q == SUM_W'($past(fill_value)) * SUM_W'(hcsm_pkg::RING_DEPTH))
		else $error("running sum wrong after fill");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.fill && ctl.write))
		else $error("fill and write in one cycle");
`endif

endmodule

### verif/hcsm_checker.sv
// Checker for the hall commutation speed meter: predicts every tick result and compares.
module hcsm_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [hcsm_pkg::S_DATA_W-1:0]    s_tdata,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [hcsm_pkg::M_DATA_W-1:0]    m_tdata,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [hcsm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hcsm_pkg::CFG_DAT_W-1:0]   cfg_data,
	output int                               errors,
	output int                               pending,
	output int                               n_checked,
	output int                               n_comm,
	output int                               n_stop,
	output int                               n_invalid
);
	timeunit 1ns;
	timeprecision 1ps;
	import hcsm_pkg::*;

	localparam int CNT_W = 16;
	localparam logic [OUT_SPD_W-1:0] SPEED_MAX = 32'h7FFF_FFFF;

	// One result transaction, laid out as on m_tdata (MSB first).
	typedef struct packed {
		logic [1:0]           pad;
		logic                 invalid;
		logic                 stopped;
		logic [OUT_SPD_W-1:0] speed;
		logic [STEP_W-1:0]    step;
		logic                 commutate;
	} tick_result_t;

	// Register copies.
	logic [TIMEOUT_W-1:0] cfg_timeout;
	logic [NUM_W-1:0]     cfg_numer;
	logic [MAP_W-1:0]     cfg_map;
	logic [TABLE_W-1:0]   cfg_steps;

	// Motor tracking state.
	logic [CNT_W-1:0]     ticks;
	logic [CNT_W-1:0]     periods [RING_DEPTH];
	logic [PTR_W-1:0]     slot;
	logic [SECTOR_W-1:0]  prev_sector;
	logic [STEP_W-1:0]    issued_step;
	logic [OUT_SPD_W-1:0] speed_reg;

	tick_result_t due_results [$];
	tick_result_t got;
	tick_result_t want;
	tick_result_t fresh;

	// Prints one mismatch line and counts it.
	task automatic report(input string what, input logic [OUT_SPD_W-1:0] seen,
			input logic [OUT_SPD_W-1:0] wanted);
		$display("%0t ns: result %0d, %s is %0h, expected %0h", $time, n_checked, what,
			seen, wanted);
		errors++;
	endtask

	// Advances the tracking state by one tick and works out its result.
	task automatic advance_commutation(input logic [HALL_W-1:0] code, input logic rev,
			output tick_result_t r);
		logic [SECTOR_W-1:0] sector;
		logic [18:0]         total;
		logic [NUM_W-1:0]    quo;
		logic [OUT_SPD_W-1:0] mag;
		int                  shift;
		r = '0;
		sector = '0;

		// Saturating tick count and stop detection, on every tick.
		if (ticks != '1)
			ticks = ticks + 1'b1;
		if (ticks > cfg_timeout) begin
			ticks = cfg_timeout;
			foreach (periods[i])
				periods[i] = cfg_timeout;
			speed_reg = '0;
			r.stopped = 1'b1;
		end

		// Decode the hall code; scanning downward leaves the lowest matching entry.
		for (int i = RING_DEPTH - 1; i >= 0; i--)
			if (cfg_map[3*i +: 3] == code)
				sector = SECTOR_W'(i + 1);

		if (sector != '0) begin
			if (sector != prev_sector || issued_step == '0) begin
				r.commutate = 1'b1;
				slot = (slot == PTR_W'(RING_DEPTH - 1)) ? '0 : slot + 1'b1;
				periods[slot] = ticks;
				ticks = '0;
				total = '0;
				foreach (periods[i])
					total += 19'(periods[i]);
				if (total == '0)
					total = 19'd1;
				quo = cfg_numer / NUM_W'(total);
				mag = (quo > SPEED_MAX) ? SPEED_MAX : quo;
				speed_reg = rev ? -mag : mag;
				shift = 3 * (int'(sector) - 1) + (rev ? ROW_W : 0);
				issued_step = cfg_steps[shift +: 3];
			end
			prev_sector = sector;
		end else begin
			r.invalid = 1'b1;
		end
		r.step = issued_step;
		r.speed = speed_reg;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_timeout = TIMEOUT_RESET;
			cfg_numer = NUMER_RESET;
			cfg_map = MAP_RESET;
			cfg_steps = TABLE_RESET;
			ticks = '0;
			foreach (periods[i])
				periods[i] = TIMEOUT_RESET;
			slot = '0;
			prev_sector = '0;
			issued_step = '0;
			speed_reg = '0;
			due_results.delete();
			errors = 0;
			n_checked = 0;
			n_comm = 0;
			n_stop = 0;
			n_invalid = 0;
		end else begin
			// Register writes.
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TIMEOUT: cfg_timeout = cfg_data[TIMEOUT_W-1:0];
					REG_NUMER:   cfg_numer = cfg_data[NUM_W-1:0];
					REG_MAP:     cfg_map = cfg_data[MAP_W-1:0];
					REG_TABLE:   cfg_steps = cfg_data[TABLE_W-1:0];
					default: ;
				endcase
			end

			// Compare a result transaction with the oldest prediction.
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (due_results.size() == 0) begin
					report("unexpected result transaction", '0, '0);
				end else begin
					want = due_results.pop_front();
					if (got.commutate !== want.commutate)
						report("commutate", got.commutate, want.commutate);
					if (got.step !== want.step)
						report("drive_step", got.step, want.step);
					if (got.speed !== want.speed)
						report("speed", got.speed, want.speed);
					if (got.stopped !== want.stopped)
						report("stopped", got.stopped, want.stopped);
					if (got.invalid !== want.invalid)
						report("hall_invalid", got.invalid, want.invalid);
					n_comm += want.commutate;
					n_stop += want.stopped;
					n_invalid += want.invalid;
				end
				n_checked++;
			end

			// Predict the result of each accepted tick.
			if (s_tvalid && s_tready) begin
				advance_commutation(s_tdata[HALL_W-1:0], s_tdata[HALL_W], fresh);
				due_results.push_back(fresh);
			end
		end
		pending = due_results.size();
	end

endmodule

### verif/tb_hall_commutation_speed_meter.sv
// Testbench top for the hall commutation speed meter: stimulus, reset and verdict.
module tb_hall_commutation_speed_meter;
	timeunit 1ns;
	timeprecision 1ps;
	import hcsm_pkg::*;

	localparam int CYCLE_LIMIT = 250_000;
	localparam int RANDOM_ITEMS = 95;

	// Map with repeated codes and with codes 0 and 7 in use (sector 6 down to 1).
	localparam logic [MAP_W-1:0] DUP_MAP = {3'd7, 3'd0, 3'd6, 3'd3, 3'd5, 3'd3};
	// Step rows holding 0 and 7 entries: reverse row, then forward row.
	localparam logic [TABLE_W-1:0] EDGE_STEPS = {3'd3, 3'd4, 3'd5, 3'd6, 3'd0, 3'd7,
		3'd4, 3'd3, 3'd2, 3'd1, 3'd7, 3'd0};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	// [2:0] hall_bits, [3] reverse, [7:4] zero.
	logic [S_DATA_W-1:0]    s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// [0] commutate, [3:1] drive_step, [35:4] speed, [36] stopped, [37] hall_invalid.
	logic [M_DATA_W-1:0]    m_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DAT_W-1:0]   cfg_data = '0;

	int errors;
	int pending;
	int n_checked;
	int n_comm;
	int n_stop;
	int n_invalid;

	int cycle_count = 0;
	int hold_req = 0;
	int phases = 0;
	bit idling = 1'b1;
	logic [MAP_W-1:0] map_now = MAP_RESET;

	always #6 clk = ~clk;

	hall_commutation_speed_meter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	hcsm_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending),
		.n_checked (n_checked),
		.n_comm    (n_comm),
		.n_stop    (n_stop),
		.n_invalid (n_invalid)
	);

	// Run guard.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
				pending);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Result side: random ready gaps, plus one long hold-off on request.
	initial begin
		int gap;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			gap = idling ? $urandom_range(0, 14) : 0;
			if (hold_req != 0) begin
				gap = hold_req;
				hold_req = 0;
			end
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(negedge clk); while (!m_tvalid);
			@(posedge clk);
		end
	end

	// Offers one tick transaction and returns at the edge that accepts it.
	task automatic send_tick(input logic [HALL_W-1:0] code, input logic rev);
		int gap;
		gap = idling ? $urandom_range(0, 14) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, rev, code};
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
	endtask

	// Waits until every tick result has come back.
	task automatic settle(input int extra);
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
	endtask

	// Writes all four registers; unused upper data bits carry random junk.
	task automatic load_config(input logic [TIMEOUT_W-1:0] t, input logic [NUM_W-1:0] n,
			input logic [MAP_W-1:0] m, input logic [TABLE_W-1:0] s);
		logic [CFG_DAT_W-1:0] junk;
		junk = CFG_DAT_W'({$urandom, $urandom});
		settle(8);
		write_reg(REG_TIMEOUT, {junk[CFG_DAT_W-1:TIMEOUT_W], t});
		write_reg(REG_NUMER, {junk[CFG_DAT_W-1:NUM_W], n});
		write_reg(REG_MAP, {junk[CFG_DAT_W-1:MAP_W], m});
		write_reg(REG_TABLE, s);
		cfg_valid <= 1'b0;
		map_now = m;
		phases++;
	endtask

	function automatic logic [HALL_W-1:0] code_of(input int sec);
		return map_now[3*(sec-1) +: 3];
	endfunction

	// Six distinct codes in random order.
	function automatic logic [MAP_W-1:0] shuffled_map();
		logic [HALL_W-1:0] codes [8];
		logic [HALL_W-1:0] t;
		logic [MAP_W-1:0]  m;
		int                j;
		for (int i = 0; i < 8; i++)
			codes[i] = HALL_W'(i);
		for (int i = 7; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = codes[i];
			codes[i] = codes[j];
			codes[j] = t;
		end
		m = '0;
		for (int i = 0; i < RING_DEPTH; i++)
			m[3*i +: 3] = codes[i];
		return m;
	endfunction

	// Mostly proper rotations with random dwell, the rest random codes.
	task automatic run_random(input int count, input int dwell_max);
		int sec;
		int dwell;
		logic rev;
		sec = $urandom_range(1, 6);
		rev = 1'($urandom_range(0, 1));
		dwell = 0;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 9) < 2) begin
				send_tick(HALL_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
			end else begin
				if (dwell == 0) begin
					if ($urandom_range(0, 19) == 0)
						rev = ~rev;
					if (rev)
						sec = (sec == 1) ? 6 : sec - 1;
					else
						sec = (sec == 6) ? 1 : sec + 1;
					dwell = ($urandom_range(0, 7) == 0) ? $urandom_range(1, dwell_max) :
						$urandom_range(1, 3);
				end
				send_tick(code_of(sec), rev);
				dwell--;
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: invalid codes before any step, rotation both ways.
		send_tick(3'd0, 1'b0);
		send_tick(3'd7, 1'b1);
		send_tick(3'd6, 1'b0);
		send_tick(3'd6, 1'b0);
		send_tick(3'd2, 1'b0);
		send_tick(3'd3, 1'b0);
		send_tick(3'd1, 1'b0);
		send_tick(3'd5, 1'b0);
		send_tick(3'd4, 1'b0);
		send_tick(3'd5, 1'b1);
		send_tick(3'd1, 1'b1);
		send_tick(3'd3, 1'b1);
		send_tick(3'd0, 1'b1);

		// Timeout of one, repeated codes in the map, zero and seven steps.
		idling = 1'b0;
		load_config(16'd1, 32'hFFFF_FFFF, DUP_MAP, EDGE_STEPS);
		send_tick(3'd3, 1'b0);
		send_tick(3'd3, 1'b0);
		send_tick(3'd5, 1'b0);
		send_tick(3'd5, 1'b0);
		send_tick(3'd5, 1'b0);
		send_tick(3'd1, 1'b0);
		send_tick(3'd0, 1'b1);
		send_tick(3'd7, 1'b1);
		send_tick(3'd6, 1'b1);
		send_tick(3'd4, 1'b1);

		// Zero timeout empties the ring: zero period sum and clamped speed both ways.
		load_config(16'd0, 32'hFFFF_FFFF, MAP_RESET, TABLE_RESET);
		send_tick(3'd6, 1'b0);
		send_tick(3'd2, 1'b1);
		send_tick(3'd2, 1'b1);

		// Longest timeout: hold one sector for a long dwell without a stop.
		load_config(16'hFFFF, 32'd1, MAP_RESET, TABLE_RESET);
		send_tick(3'd6, 1'b0);
		repeat (40) send_tick(3'd6, 1'b0);
		send_tick(3'd2, 1'b0);
		send_tick(3'd3, 1'b0);

		// Random phases.
		idling = 1'b1;
		load_config(TIMEOUT_RESET, NUMER_RESET, MAP_RESET, TABLE_RESET);
		run_random(RANDOM_ITEMS, 20);

		load_config(TIMEOUT_W'($urandom_range(2, 30)), $urandom, MAP_RESET,
			TABLE_W'({$urandom, $urandom}));
		hold_req = 400;
		run_random(RANDOM_ITEMS, 60);

		idling = 1'b0;
		load_config(16'hFFFF, 32'hFFFF_FFFF, shuffled_map(), TABLE_W'({$urandom, $urandom}));
		run_random(RANDOM_ITEMS, 10);

		idling = 1'b1;
		load_config(16'd1, 32'd1, shuffled_map(), TABLE_RESET);
		run_random(RANDOM_ITEMS, 5);

		load_config(TIMEOUT_W'($urandom_range(1, 200)), $urandom,
			MAP_W'($urandom_range(0, 2**MAP_W - 1)), TABLE_W'({$urandom, $urandom}));
		run_random(RANDOM_ITEMS, 400);

		load_config(TIMEOUT_RESET, NUMER_RESET, MAP_RESET, TABLE_RESET);
		run_random(RANDOM_ITEMS, 20);

		settle(60);
		$display("Checked %0d tick results: %0d commutations, %0d stops, %0d invalid codes.",
			n_checked, n_comm, n_stop, n_invalid);
		$display("Register settings used: %0d besides reset, including the timeout extremes.",
			phases);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

### filelist.f
sv/hcsm_pkg.sv
sv/hcsm_divider.sv
sv/hcsm_period_ring.sv
sv/hall_commutation_speed_meter.sv
verif/hcsm_checker.sv
verif/tb_hall_commutation_speed_meter.sv
